### rtl/fresnel_reflectance_core_macros.svh
// Assertion macros for the RTL file that carries checks (fresnel_reflectance_core).
`ifndef FRESNEL_REFLECTANCE_CORE_MACROS_SVH
`define FRESNEL_REFLECTANCE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, idle during reset.
`define FRC_ASSERT_IMPLY(name, cond, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("assertion failed");
// Next-cycle implication, sampled on clk, idle during reset.
`define FRC_ASSERT_NEXT(name, cond, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define FRC_ASSERT_IMPLY(name, cond, expr)
`define FRC_ASSERT_NEXT(name, cond, expr)
`endif

`endif

### rtl/frc_pkg.sv
package frc_pkg;
	localparam int F    = 16;
	localparam int CW   = F + 2;
	localparam int IW   = F + 8;
	localparam int OW   = F + 1;
	localparam int G2W  = 2 * IW + 1;
	localparam int GW   = (G2W + 1) / 2;
	localparam int RADW = 2 * GW;
	localparam int SRW  = GW + 3;
	localparam int GPW  = GW + 1;
	localparam int DRW  = GPW + 1;
	localparam int QW   = F + 1;

	localparam logic [OW-1:0] ONE = OW'(1) << F;

	typedef struct packed {
		logic          err;
		logic          full;
		logic          bsat;
		logic [OW-1:0] c;
	} side_t;
endpackage

### rtl/fresnel_reflectance_core.sv
// Channel  Handshake                   Payload
// item     item_valid / item_ready     cosine, index
// result   result_valid / result_ready reflectance, index_error
//
// One item enters every cycle unless the result side stalls; the pipe is 51 register
// stages deep. The depth is set by three front stages, the
// 25-stage square root (one root bit per stage), three middle stages, the 17-stage
// dual divider (one quotient bit per stage) and three back stages.
// Reset clears only the valid bits of every stage.
// A stall on the result side freezes the whole pipe; item_ready follows it at once.
`include "fresnel_reflectance_core_macros.svh"

module fresnel_reflectance_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [frc_pkg::CW-1:0] cosine,
	input  logic        [frc_pkg::IW-1:0] index,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic        [frc_pkg::OW-1:0] reflectance,
	output logic                          index_error
);
	import frc_pkg::*;

	localparam logic [RADW-1:0] ONE_SQ = RADW'(1) << (2 * F);
	localparam int PW  = OW + GPW;
	localparam int PRW = 2 * OW + 1;

	logic en;

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic                vld_s7, vld_s8, vld_s9;
	side_t               side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	side_t               side_s7, side_s8, side_s9;
	logic [IW-1:0]       n_s1;
	logic [2*IW-1:0]     nn_s2;
	logic [2*OW-1:0]     cc_s2;
	logic [RADW-1:0]     rad_s3;
	logic [GPW-1:0]      gm_s4, gp_s4, gm_s5, gp_s5;
	logic [PW-1:0]       cgp_s5, cgm_s5;
	logic [GPW-1:0]      xa_s6, da_s6, xb_s6, db_s6;
	logic [OW-1:0]       a2_s7, b2_s7;
	logic [PRW-1:0]      prod_s8;
	logic [OW-1:0]       f_s9;

	logic                sq_vld, dv_vld;
	logic [GW-1:0]       g;
	side_t               sq_side, dv_side, side_in, side_b;
	logic [QW-1:0]       qa, qb;
	logic [OW-1:0]       c_in;
	logic [GPW-1:0]      g_ext, cgp, t1mag, t2;
	logic [OW-1:0]       b;
	logic [2*OW-1:0]     aa, bb;
	logic [PRW-OW-1:0]   f_raw;

	assign en           = !vld_s9 || result_ready;
	assign item_ready   = en;
	assign result_valid = vld_s9;
	assign reflectance  = f_s9;
	assign index_error  = side_s9.err;

	// Classify and clamp the cosine to 1.0
	always_comb begin
		side_in      = '0;
		side_in.err  = index < IW'(ONE);
		side_in.full = !side_in.err && (cosine[CW-1] || cosine == '0);
		c_in         = (cosine > CW'(ONE)) ? ONE : cosine[OW-1:0];
		side_in.c    = c_in;
	end

	always_comb begin
		g_ext       = {1'b0, g};
		cgp         = cgp_s5[F +: GPW];
		t1mag       = (cgp >= GPW'(ONE)) ? cgp - GPW'(ONE) : GPW'(ONE) - cgp;
		t2          = cgm_s5[F +: GPW] + GPW'(ONE);
		side_b      = side_s5;
		side_b.bsat = {1'b0, t1mag} >= {t2, 1'b0};
		b           = (dv_side.bsat || qb > ONE) ? ONE : qb;
		aa          = qa * qa;
		bb          = b * b;
		f_raw       = prod_s8[PRW-1:F+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= sq_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= dv_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			n_s1    <= index;

			side_s2 <= side_s1;
			nn_s2   <= n_s1 * n_s1;
			cc_s2   <= side_s1.c * side_s1.c;

			side_s3 <= side_s2;
			// Special items skip the root: feed zero
			rad_s3  <= (side_s2.err || side_s2.full) ? '0 :
				RADW'(nn_s2) + RADW'(cc_s2) - ONE_SQ;

			side_s4 <= sq_side;
			gm_s4   <= (g_ext >= GPW'(sq_side.c)) ? g_ext - GPW'(sq_side.c) : '0;
			gp_s4   <= g_ext + GPW'(sq_side.c);

			side_s5 <= side_s4;
			gm_s5   <= gm_s4;
			gp_s5   <= gp_s4;
			cgp_s5  <= side_s4.c * gp_s4;
			cgm_s5  <= side_s4.c * gm_s4;

			side_s6 <= side_b;
			xa_s6   <= gm_s5;
			da_s6   <= gp_s5;
			// Quotient beyond two saturates anyway: drop the dividend
			xb_s6   <= side_b.bsat ? '0 : t1mag;
			db_s6   <= t2;

			side_s7 <= dv_side;
			a2_s7   <= aa[F +: OW];
			b2_s7   <= bb[F +: OW];

			side_s8 <= side_s7;
			prod_s8 <= a2_s7 * ({1'b0, ONE} + {1'b0, b2_s7});

			side_s9 <= side_s8;
			if (side_s8.err) begin
				f_s9 <= '0;
			end else if (side_s8.full || f_raw > {1'b0, ONE}) begin
				f_s9 <= ONE;
			end else begin
				f_s9 <= f_raw[OW-1:0];
			end
		end
	end

	frc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.rad      (rad_s3),
		.in_side  (side_s3),
		.out_vld  (sq_vld),
		.root     (g),
		.out_side (sq_side)
	);

	frc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s6),
		.xa       (xa_s6),
		.da       (da_s6),
		.xb       (xb_s6),
		.db       (db_s6),
		.in_side  (side_s6),
		.out_vld  (dv_vld),
		.qa       (qa),
		.qb       (qb),
		.out_side (dv_side)
	);

	`FRC_ASSERT_IMPLY(a_err_zero, result_valid && index_error, reflectance == '0)
	`FRC_ASSERT_IMPLY(a_in_range, result_valid, reflectance <= ONE)
	`FRC_ASSERT_NEXT(a_err_entry, item_valid && item_ready && (index < IW'(ONE)), vld_s1 && side_s1.err)
endmodule

### rtl/frc_sqrt.sv
module frc_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_vld,
	input  logic [frc_pkg::RADW-1:0] rad,
	input  frc_pkg::side_t           in_side,
	output logic                     out_vld,
	output logic [frc_pkg::GW-1:0]   root,
	output frc_pkg::side_t           out_side
);
	import frc_pkg::*;

	logic            vld_s  [GW];
	logic [RADW-1:0] rad_s  [GW];
	logic [SRW-1:0]  rem_s  [GW];
	logic [GW-1:0]   root_s [GW];
	side_t           side_s [GW];

	// One result bit per stage, radicand consumed two bits at a time from the top
	for (genvar i = 0; i < GW; i++) begin : g_stage
		logic            vld_p;
		logic [RADW-1:0] rad_p;
		logic [SRW-1:0]  rem_p;
		logic [GW-1:0]   root_p;
		side_t           side_p;
		logic [SRW-1:0]  rem_sh;
		logic [SRW-1:0]  trial;
		logic            take;

		if (i == 0) begin : g_first
			assign vld_p  = in_vld;
			assign rad_p  = rad;
			assign rem_p  = '0;
			assign root_p = '0;
			assign side_p = in_side;
		end else begin : g_next
			assign vld_p  = vld_s[i-1];
			assign rad_p  = rad_s[i-1];
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign side_p = side_s[i-1];
		end

		assign rem_sh = {rem_p[SRW-3:0], rad_p[RADW-1 -: 2]};
		assign trial  = {1'b0, root_p, 2'b01};
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i]  <= rad_p << 2;
				rem_s[i]  <= take ? rem_sh - trial : rem_sh;
				root_s[i] <= {root_p[GW-2:0], take};
				side_s[i] <= side_p;
			end
		end
	end

	assign out_vld  = vld_s[GW-1];
	assign root     = root_s[GW-1];
	assign out_side = side_s[GW-1];
endmodule

### rtl/frc_div.sv
module frc_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic [frc_pkg::GPW-1:0] xa,
	input  logic [frc_pkg::GPW-1:0] da,
	input  logic [frc_pkg::GPW-1:0] xb,
	input  logic [frc_pkg::GPW-1:0] db,
	input  frc_pkg::side_t          in_side,
	output logic                    out_vld,
	output logic [frc_pkg::QW-1:0]  qa,
	output logic [frc_pkg::QW-1:0]  qb,
	output frc_pkg::side_t          out_side
);
	import frc_pkg::*;

	// Two restoring dividers side by side: q = (x << F) / d, valid for x < 2d
	logic           vld_s  [QW];
	logic [DRW-1:0] ra_s   [QW];
	logic [DRW-1:0] rb_s   [QW];
	logic [GPW-1:0] da_s   [QW];
	logic [GPW-1:0] db_s   [QW];
	logic [QW-1:0]  qa_s   [QW];
	logic [QW-1:0]  qb_s   [QW];
	side_t          side_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic           vld_p;
		logic [DRW-1:0] ra_p, rb_p;
		logic [GPW-1:0] da_p, db_p;
		logic [QW-1:0]  qa_p, qb_p;
		side_t          side_p;
		logic           ta, tb;

		if (i == 0) begin : g_first
			assign vld_p  = in_vld;
			assign ra_p   = {1'b0, xa};
			assign rb_p   = {1'b0, xb};
			assign da_p   = da;
			assign db_p   = db;
			assign qa_p   = '0;
			assign qb_p   = '0;
			assign side_p = in_side;
		end else begin : g_next
			assign vld_p  = vld_s[i-1];
			assign ra_p   = {ra_s[i-1][DRW-2:0], 1'b0};
			assign rb_p   = {rb_s[i-1][DRW-2:0], 1'b0};
			assign da_p   = da_s[i-1];
			assign db_p   = db_s[i-1];
			assign qa_p   = qa_s[i-1];
			assign qb_p   = qb_s[i-1];
			assign side_p = side_s[i-1];
		end

		assign ta = ra_p >= {1'b0, da_p};
		assign tb = rb_p >= {1'b0, db_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[i]   <= ta ? ra_p - {1'b0, da_p} : ra_p;
				rb_s[i]   <= tb ? rb_p - {1'b0, db_p} : rb_p;
				da_s[i]   <= da_p;
				db_s[i]   <= db_p;
				qa_s[i]   <= {qa_p[QW-2:0], ta};
				qb_s[i]   <= {qb_p[QW-2:0], tb};
				side_s[i] <= side_p;
			end
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign qa       = qa_s[QW-1];
	assign qb       = qb_s[QW-1];
	assign out_side = side_s[QW-1];
endmodule
